// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the gradient interval table.
// Plain text macros only; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence");

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`endif

// ===== hdl/git_pkg.sv =====
// Package of the gradient interval table: payload types, state codes,
// command and status bundles, fixed-point helpers. No dependencies.
package git_pkg;

    localparam int POS_W     = 20;
    localparam int COL_W     = 16;
    localparam int VAL_W     = 32;
    localparam int IDX_OUT_W = 5;
    localparam int NCH       = 4;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 21;
    localparam int PROD_W    = POS_W + VAL_W;
    localparam int DIFF_W    = PROD_W - 16 + 1;
    localparam int DIV_CNT_W = 5;

    localparam logic signed [POS_W-1:0] POS_NEG_INF = 20'sh80000;
    localparam logic signed [POS_W-1:0] POS_POS_INF = 20'sh7FFFF;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_NEXT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NOMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]             kind;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] position_end;
        logic                   increasing;
        logic signed [COL_W-1:0] start_red;
        logic signed [COL_W-1:0] start_green;
        logic signed [COL_W-1:0] start_blue;
        logic signed [COL_W-1:0] start_alpha;
        logic signed [COL_W-1:0] end_red;
        logic signed [COL_W-1:0] end_green;
        logic signed [COL_W-1:0] end_blue;
        logic signed [COL_W-1:0] end_alpha;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [IDX_OUT_W-1:0]   entry_index;
        logic signed [VAL_W-1:0] bias_red;
        logic signed [VAL_W-1:0] bias_green;
        logic signed [VAL_W-1:0] bias_blue;
        logic signed [VAL_W-1:0] bias_alpha;
        logic signed [VAL_W-1:0] slope_red;
        logic signed [VAL_W-1:0] slope_green;
        logic signed [VAL_W-1:0] slope_blue;
        logic signed [VAL_W-1:0] slope_alpha;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0]     start_pos;
        logic signed [POS_W-1:0]     end_pos;
        logic [NCH-1:0][VAL_W-1:0]   bias;
        logic [NCH-1:0][VAL_W-1:0]   slope;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_SLOPE,
        S_PROD,
        S_BIAS,
        S_BS_ISSUE,
        S_BS_CMP,
        S_CHK_ISSUE,
        S_CHK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       div_step;
        logic       slope;
        logic       prod;
        logic       bias_write;
        logic       bs_read;
        logic       bs_update;
        logic       nx_init;
        logic       nx_advance;
        logic       chk_read;
        logic       res_hit;
        logic       res_zero;
        logic [1:0] res_code;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       div_last;
        logic       bs_done;
        logic       hit;
        logic       nx_last;
        logic       out_free;
        logic       cur_ok;
    } t_sts;

    function automatic logic is_inf(input logic signed [POS_W-1:0] p);
        return (p == POS_NEG_INF) || (p == POS_POS_INF);
    endfunction

    // Apply sign to an unsigned quotient and clamp to int32.
    function automatic logic [VAL_W-1:0] sat_slope(input logic neg, input logic [NUM_W-1:0] q);
        logic [VAL_W-1:0] r;
        if (!neg) begin
            r = q[NUM_W-1] ? 32'h7FFF_FFFF : q;
        end else begin
            r = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] sat_bias(input logic [DIFF_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v[DIFF_W-1:VAL_W-1] == '0 || v[DIFF_W-1:VAL_W-1] == '1) begin
            r = v[VAL_W-1:0];
        end else begin
            r = v[DIFF_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== hdl/git_chan.sv =====
// Valid/ready channel interface for the gradient interval table.
// Payload type is set by the instantiating scope; no other dependencies.
interface git_chan #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/git_ctrl.sv =====
// Controller of the gradient interval table: sequences clear, append, binary
// search and wrap-around walk. Depends on git_pkg.
module git_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_ready,
    input  git_pkg::t_sts i_sts,
    output git_pkg::t_cmd o_cmd
);
    import git_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_CLEAR:  n_state = S_RESP;
                    KIND_APPEND: n_state = i_sts.full ? S_RESP : S_DIV;
                    KIND_FIND:   n_state = i_sts.empty ? S_RESP : S_BS_ISSUE;
                    KIND_NEXT:   n_state = i_sts.empty ? S_RESP : S_CHK_ISSUE;
                    default:     n_state = S_RESP;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_SLOPE;
            end
            S_SLOPE:     n_state = S_PROD;
            S_PROD:      n_state = S_BIAS;
            S_BIAS:      n_state = S_RESP;
            S_BS_ISSUE:  n_state = i_sts.bs_done ? S_CHK : S_BS_CMP;
            S_BS_CMP:    n_state = S_BS_ISSUE;
            S_CHK_ISSUE: n_state = S_CHK;
            S_CHK: begin
                if (i_sts.hit || i_sts.kind == KIND_FIND || i_sts.nx_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_CHK_ISSUE;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.res_zero = 1'b1;
                        o_cmd.res_code = STAT_OK;
                    end
                    KIND_APPEND: begin
                        o_cmd.res_zero = i_sts.full;
                        o_cmd.res_code = STAT_FULL;
                    end
                    KIND_FIND: begin
                        o_cmd.res_zero = i_sts.empty;
                        o_cmd.res_code = STAT_NOMATCH;
                    end
                    KIND_NEXT: begin
                        o_cmd.res_zero = i_sts.empty;
                        o_cmd.res_code = STAT_NOMATCH;
                        o_cmd.nx_init  = !i_sts.empty;
                    end
                    default: o_cmd.res_code = STAT_OK;
                endcase
            end
            S_DIV:   o_cmd.div_step   = 1'b1;
            S_SLOPE: o_cmd.slope      = 1'b1;
            S_PROD:  o_cmd.prod       = 1'b1;
            S_BIAS:  o_cmd.bias_write = 1'b1;
            S_BS_ISSUE: begin
                o_cmd.chk_read = i_sts.bs_done;
                o_cmd.bs_read  = !i_sts.bs_done;
            end
            S_BS_CMP:    o_cmd.bs_update = 1'b1;
            S_CHK_ISSUE: o_cmd.chk_read  = 1'b1;
            S_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.res_hit = 1'b1;
                end else if (i_sts.kind == KIND_FIND || i_sts.nx_last) begin
                    o_cmd.res_zero = 1'b1;
                    o_cmd.res_code = STAT_NOMATCH;
                end else begin
                    o_cmd.nx_advance = 1'b1;
                end
            end
            S_RESP: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/git_dp.sv =====
// Datapath of the gradient interval table: interval memory, four serial
// dividers, slope/bias arithmetic, search indexes, result register. Uses git_pkg.
module git_dp #(
    parameter int MAX_INTERVALS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  git_pkg::t_in_item  i_item,
    input  git_pkg::t_cmd      i_cmd,
    output git_pkg::t_sts      o_sts,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output git_pkg::t_out_item o_res
);
    import git_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    t_entry r_mem [MAX_INTERVALS];
    t_entry r_rd;

    t_in_item r_item;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_lo;
    logic [IW-1:0] r_hi;
    logic [IW-1:0] r_mid;
    logic [CW-1:0] r_k;

    logic [NCH-1:0][NUM_W-1:0] r_quo;
    logic [NCH-1:0][DEN_W-1:0] r_rem;
    logic [NCH-1:0]            r_neg;
    logic [DEN_W-1:0]          r_den;
    logic                      r_zero_slope;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic [NCH-1:0][VAL_W-1:0] r_slope;
    logic [NCH-1:0][PROD_W-1:0] r_prod;

    logic [1:0]                r_res_status;
    logic [IW-1:0]             r_res_idx;
    logic [NCH-1:0][VAL_W-1:0] r_res_bias;
    logic [NCH-1:0][VAL_W-1:0] r_res_slope;

    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [NCH-1:0][COL_W-1:0] w_c0_in;
    logic [NCH-1:0][COL_W-1:0] w_c1_in;
    logic [NCH-1:0][COL_W-1:0] w_c0;
    logic [NCH-1:0][VAL_W-1:0] w_bias;
    logic signed [DEN_W-1:0]   w_dt;
    logic [IW-1:0]             w_mid;
    logic [IW-1:0]             w_rd_addr;
    logic [IW-1:0]             w_clamp;
    logic                      w_hit;
    logic                      w_out_free;
    t_entry                    w_new;

    function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] i, input logic inc,
                                               input logic [CW-1:0] cnt);
        logic [IW-1:0] r;
        if (inc) begin
            r = ((CW'(i) + 1'b1) >= cnt) ? '0 : i + 1'b1;
        end else begin
            r = (i == '0) ? IW'(cnt - 1'b1) : i - 1'b1;
        end
        return r;
    endfunction

    assign w_c0_in = {i_item.start_alpha, i_item.start_blue, i_item.start_green,
                      i_item.start_red};
    assign w_c1_in = {i_item.end_alpha, i_item.end_blue, i_item.end_green, i_item.end_red};
    assign w_c0    = {r_item.start_alpha, r_item.start_blue, r_item.start_green,
                      r_item.start_red};

    assign w_dt = {i_item.position_end[POS_W-1], i_item.position_end}
                - {i_item.position[POS_W-1], i_item.position};

    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rd_addr = i_cmd.bs_read ? w_mid : r_lo;
    assign w_clamp   = (CW'(r_cur) >= r_count) ? IW'(r_count - 1'b1) : r_cur;
    assign w_hit     = (r_item.position >= r_rd.start_pos) && (r_item.position <= r_rd.end_pos);

    // Bias: c0 minus floor(t0 * slope / 2^16), or c0 itself for an infinite start.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (is_inf(r_item.position)) begin
                w_bias[c] = VAL_W'(signed'(w_c0[c]));
            end else begin
                w_bias[c] = sat_bias(DIFF_W'(signed'(w_c0[c]))
                                     - DIFF_W'(signed'(r_prod[c][PROD_W-1:16])));
            end
        end
    end

    assign w_new.start_pos = r_item.position;
    assign w_new.end_pos   = r_item.position_end;
    assign w_new.bias      = w_bias;
    assign w_new.slope     = r_slope;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cur   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_cur   <= '0;
            end else if (i_cmd.bias_write) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.res_hit) begin
                r_cur <= r_lo;
            end
        end
    end

    // Input capture, divider and search indexes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            logic signed [COL_W:0] diff;
            r_item       <= i_item;
            r_lo         <= '0;
            r_hi         <= IW'(r_count - 1'b1);
            r_div_cnt    <= '0;
            r_den        <= w_dt[DEN_W-1] ? -w_dt : w_dt;
            r_zero_slope <= is_inf(i_item.position) || is_inf(i_item.position_end)
                            || (w_dt == '0);
            for (int c = 0; c < NCH; c++) begin
                diff = {w_c1_in[c][COL_W-1], w_c1_in[c]} - {w_c0_in[c][COL_W-1], w_c0_in[c]};
                r_neg[c] <= diff[COL_W] ^ w_dt[DEN_W-1];
                r_quo[c] <= {(diff[COL_W] ? 16'(-diff) : diff[COL_W-1:0]), 16'h0000};
                r_rem[c] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            logic [DEN_W:0] rr;
            r_div_cnt <= r_div_cnt + 1'b1;
            for (int c = 0; c < NCH; c++) begin
                rr = {r_rem[c], r_quo[c][NUM_W-1]};
                if (rr >= {1'b0, r_den}) begin
                    r_rem[c] <= DEN_W'(rr - {1'b0, r_den});
                    r_quo[c] <= {r_quo[c][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= rr[DEN_W-1:0];
                    r_quo[c] <= {r_quo[c][NUM_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.slope) begin
            for (int c = 0; c < NCH; c++) begin
                r_slope[c] <= r_zero_slope ? '0 : sat_slope(r_neg[c], r_quo[c]);
            end
        end
        if (i_cmd.prod) begin
            for (int c = 0; c < NCH; c++) begin
                r_prod[c] <= PROD_W'(r_item.position * signed'(r_slope[c]));
            end
        end
        if (i_cmd.bs_read) begin
            r_mid <= w_mid;
        end
        if (i_cmd.bs_update) begin
            if (r_item.position > r_rd.end_pos) r_lo <= r_mid + 1'b1;
            else r_hi <= r_mid;
        end
        if (i_cmd.nx_init) begin
            r_lo <= step_idx(w_clamp, r_item.increasing, r_count);
            r_k  <= '0;
        end
        if (i_cmd.nx_advance) begin
            r_lo <= step_idx(r_lo, r_item.increasing, r_count);
            r_k  <= r_k + 1'b1;
        end
    end

    // Interval memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.bias_write) begin
            r_mem[r_count[IW-1:0]] <= w_new;
        end
        if (i_cmd.bs_read || i_cmd.chk_read) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_status <= i_cmd.res_code;
            r_res_idx    <= '0;
            r_res_bias   <= '0;
            r_res_slope  <= '0;
        end else if (i_cmd.bias_write) begin
            r_res_status <= STAT_OK;
            r_res_idx    <= r_count[IW-1:0];
            r_res_bias   <= w_bias;
            r_res_slope  <= r_slope;
        end else if (i_cmd.res_hit) begin
            r_res_status <= STAT_OK;
            r_res_idx    <= r_lo;
            r_res_bias   <= r_rd.bias;
            r_res_slope  <= r_rd.slope;
        end
    end

    // Output register; holds while the receiver stalls.
    assign w_out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status      <= r_res_status;
            r_out.entry_index <= IDX_OUT_W'(r_res_idx);
            r_out.bias_red    <= r_res_bias[0];
            r_out.bias_green  <= r_res_bias[1];
            r_out.bias_blue   <= r_res_bias[2];
            r_out.bias_alpha  <= r_res_bias[3];
            r_out.slope_red   <= r_res_slope[0];
            r_out.slope_green <= r_res_slope[1];
            r_out.slope_blue  <= r_res_slope[2];
            r_out.slope_alpha <= r_res_slope[3];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign o_sts.kind     = r_item.kind;
    assign o_sts.full     = (r_count == MAX_CNT);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.div_last = (r_div_cnt == '1);
    assign o_sts.bs_done  = (r_lo == r_hi);
    assign o_sts.hit      = w_hit;
    assign o_sts.nx_last  = (r_k == r_count - 1'b1);
    assign o_sts.out_free = w_out_free;
    assign o_sts.cur_ok   = (r_count == '0) ? (r_cur == '0) : (CW'(r_cur) < r_count);

endmodule

// ===== hdl/gradient_interval_table.sv =====
// Top level of the gradient interval table: controller plus datapath.
// Depends on git_pkg, git_chan, git_ctrl, git_dp and assert_macros.svh.
//
// Usage:
//   i_item carries one command (clear, append, find, find-next) per
//   transaction; o_result returns exactly one result per command.
//   One command is worked on at a time; i_item.ready is high only while the
//   controller is idle.
//   Sequence from acceptance to o_result.valid:
//     clear, table full, empty table: dispatch, then the response.
//     append: the 32-step restoring divider that runs the
//       four channels side by side, then slope, product and bias steps.
//     find: at most ceil(log2(entry count)) search steps, each a read and a compare.
//     find-next: a walk that stops at the first hit, visiting at most every
//       entry, one memory read per entry.
//   Reset empties the table and points the current entry at zero; the
//   interval memory itself is not cleared and needs no clearing pass.
//   A stalled receiver holds the result in the output register; the block
//   finishes its next command and then waits until the register frees.
module gradient_interval_table #(
    parameter int MAX_INTERVALS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    git_chan.sink   i_item,
    git_chan.source o_result
);
    import git_pkg::*;
    `include "assert_macros.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    git_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    git_dp #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item.payload),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_res       (o_result.payload)
    );

    assign i_item.ready = w_in_ready;

    `ASSERT_NEXT(a_emit_shows_result, i_clk, i_rst_n, w_cmd.emit, o_result.valid)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
    `ASSERT_ALWAYS(a_cur_in_table, i_clk, i_rst_n, w_sts.cur_ok)

endmodule

// ===== bench/gradient_interval_table_tb.sv =====
// Self-checking bench for gradient_interval_table: one command per transaction,
// each result compared against an in-bench model of the interval table.
// Depends on git_pkg, git_chan and gradient_interval_table from the RTL.
module gradient_interval_table_tb;
    import git_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    git_chan #(.T_PAYLOAD(t_in_item))  cmd_ch ();
    git_chan #(.T_PAYLOAD(t_out_item)) res_ch ();

    gradient_interval_table #(.MAX_INTERVALS(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (cmd_ch),
        .o_result(res_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Table model
    logic signed [POS_W-1:0] tbl_start [DEPTH];
    logic signed [POS_W-1:0] tbl_end [DEPTH];
    logic signed [VAL_W-1:0] tbl_bias [DEPTH][NCH];
    logic signed [VAL_W-1:0] tbl_slope [DEPTH][NCH];
    int unsigned tbl_count;
    int unsigned cur_entry;

    t_out_item expected_results[$];
    int mismatches;
    int idle_cycles;
    bit no_idle;
    bit hold_results;
    bit done_sending;

    function automatic logic signed [VAL_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic bit contains(int unsigned i, logic signed [POS_W-1:0] t);
        return t >= tbl_start[i] && t <= tbl_end[i];
    endfunction

    function automatic t_out_item hit_result(int unsigned i);
        t_out_item r;
        r = '0;
        r.status = STAT_OK;
        r.entry_index = i[4:0];
        r.bias_red = tbl_bias[i][0];
        r.bias_green = tbl_bias[i][1];
        r.bias_blue = tbl_bias[i][2];
        r.bias_alpha = tbl_bias[i][3];
        r.slope_red = tbl_slope[i][0];
        r.slope_green = tbl_slope[i][1];
        r.slope_blue = tbl_slope[i][2];
        r.slope_alpha = tbl_slope[i][3];
        return r;
    endfunction

    function automatic t_out_item predict_lookup(t_in_item it);
        t_out_item r;
        longint c0[NCH], c1[NCH];
        longint t0, t1, dt, p, q;
        logic signed [VAL_W-1:0] s;
        int unsigned lo, hi, mid, i;
        r = '0;
        t0 = longint'(it.position);
        t1 = longint'(it.position_end);
        case (t_kind'(it.kind))
            KIND_CLEAR: begin
                tbl_count = 0;
                cur_entry = 0;
                return r;
            end
            KIND_APPEND: begin
                if (tbl_count >= DEPTH) begin
                    r.status = STAT_FULL;
                    return r;
                end
                c0 = '{it.start_red, it.start_green, it.start_blue, it.start_alpha};
                c1 = '{it.end_red, it.end_green, it.end_blue, it.end_alpha};
                dt = t1 - t0;
                tbl_start[tbl_count] = it.position;
                tbl_end[tbl_count] = it.position_end;
                for (int c = 0; c < NCH; c++) begin
                    s = '0;
                    if (!is_inf(it.position) && !is_inf(it.position_end) && dt != 0)
                        s = clamp32(((c1[c] - c0[c]) * 65536) / dt);
                    tbl_slope[tbl_count][c] = s;
                    if (is_inf(it.position)) begin
                        tbl_bias[tbl_count][c] = 32'(c0[c]);
                    end else begin
                        p = t0 * longint'(s);
                        q = p / 65536;
                        if (p < 0 && (p % 65536) != 0) q -= 1;
                        tbl_bias[tbl_count][c] = clamp32(c0[c] - q);
                    end
                end
                tbl_count++;
                return hit_result(tbl_count - 1);
            end
            default: ;
        endcase
        r.status = STAT_NOMATCH;
        if (tbl_count == 0) return r;
        if (t_kind'(it.kind) == KIND_FIND) begin
            lo = 0;
            hi = tbl_count - 1;
            while (lo != hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (it.position > tbl_end[mid]) lo = mid + 1;
                else hi = mid;
            end
            if (!contains(lo, it.position)) return r;
            cur_entry = lo;
            return hit_result(lo);
        end
        i = (cur_entry >= tbl_count) ? tbl_count - 1 : cur_entry;
        for (int k = 0; k < tbl_count; k++) begin
            if (it.increasing) i = (i + 1 >= tbl_count) ? 0 : i + 1;
            else i = (i == 0) ? tbl_count - 1 : i - 1;
            if (contains(i, it.position)) begin
                cur_entry = i;
                return hit_result(i);
            end
        end
        return r;
    endfunction

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 7);
    endfunction

    // Leave valid high after the transaction; the next call or the caller drops it.
    task automatic send_item(t_in_item it);
        while (take_break()) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_lookup(it));
    endtask

    // Result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", res_ch.payload);
            end else begin
                if (res_ch.payload !== expected_results[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", expected_results[0],
                                 res_ch.payload);
                end
                void'(expected_results.pop_front());
            end
        end
        res_ch.ready <= !hold_results && !take_break();
    end

    always @(posedge i_clk) begin
        if (cmd_ch.valid && cmd_ch.ready || res_ch.valid && res_ch.ready) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(9))
            0: return POS_NEG_INF;
            1: return POS_POS_INF;
            2: return POS_W'($urandom_range(3) - 2);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item(t_kind k);
        t_in_item it;
        it = '0;
        it.kind = k;
        it.position = rand_pos();
        it.position_end = rand_pos();
        it.increasing = 1'($urandom);
        {it.start_red, it.start_green} = $urandom;
        {it.start_blue, it.start_alpha} = $urandom;
        {it.end_red, it.end_green} = $urandom;
        {it.end_blue, it.end_alpha} = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_item(t_kind k, int p0, int p1);
        t_in_item it;
        it = rand_item(k);
        it.position = POS_W'(p0);
        it.position_end = POS_W'(p1);
        return it;
    endfunction

    // Build a sorted table of n intervals with gaps so finds both hit and miss.
    task automatic fill_sorted(int n);
        int p;
        p = -500000 + $urandom_range(1000);
        send_item(make_item(KIND_CLEAR, 0, 0));
        for (int i = 0; i < n; i++) begin
            t_in_item it;
            int w;
            w = $urandom_range(3) == 0 ? 0 : $urandom_range(30000);
            it = make_item(KIND_APPEND, p, p + w);
            if (i == 0 && $urandom_range(1)) it.position = POS_NEG_INF;
            if (i == n - 1 && $urandom_range(1)) it.position_end = POS_POS_INF;
            send_item(it);
            p = p + w + $urandom_range(2000);
        end
    endtask

    task automatic query_positions(int n);
        for (int i = 0; i < n; i++) begin
            t_in_item it;
            it = rand_item($urandom_range(1) ? KIND_FIND : KIND_NEXT);
            if ($urandom_range(3) != 0)
                it.position = POS_W'(-500000 + $urandom_range(1000000));
            send_item(it);
        end
    endtask

    task automatic test_directed();
        t_in_item it;
        send_item(make_item(KIND_FIND, 0, 0));
        send_item(make_item(KIND_NEXT, 0, 0));
        it = make_item(KIND_APPEND, 0, 1);
        {it.start_red, it.start_green, it.start_blue, it.start_alpha} = {4{16'sh8000}};
        {it.end_red, it.end_green, it.end_blue, it.end_alpha} = {4{16'sh7FFF}};
        send_item(it);
        it = make_item(KIND_APPEND, -524287, 524286);
        send_item(it);
        send_item(make_item(KIND_APPEND, POS_NEG_INF, 5));
        send_item(make_item(KIND_APPEND, 7, POS_POS_INF));
        send_item(make_item(KIND_APPEND, 9, 9));
        send_item(make_item(KIND_APPEND, 100, 20));
        send_item(make_item(KIND_FIND, 0, 0));
        send_item(make_item(KIND_FIND, 524287, 0));
        send_item(make_item(KIND_NEXT, 9, 0));
        it = make_item(KIND_NEXT, -524288, 0);
        it.increasing = 1'b0;
        send_item(it);
        send_item(make_item(KIND_CLEAR, 0, 0));
    endtask

    task automatic test_full_table();
        fill_sorted(DEPTH);
        send_item(make_item(KIND_APPEND, 0, 5));
        query_positions(20);
        // Next on a table shrunk by a clear; the clear sets current back to zero.
        send_item(make_item(KIND_CLEAR, 0, 0));
        send_item(make_item(KIND_APPEND, -10, 10));
        send_item(make_item(KIND_NEXT, 0, 0));
    endtask

    task automatic test_backpressure();
        fill_sorted(4);
        fork
            begin
                hold_results <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_results <= 1'b0;
            end
            query_positions(12);
        join
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1300) begin
            int n;
            if ($urandom_range(9) == 0) begin
                send_item(rand_item(t_kind'($urandom_range(3))));
                sent++;
            end else begin
                n = $urandom_range(5) == 0 ? $urandom_range(DEPTH) : $urandom_range(6);
                no_idle = ($urandom_range(7) == 0);
                fill_sorted(n);
                query_positions(8);
                sent += n + 9;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        no_idle = 1'b0;
        hold_results = 1'b0;
        tbl_count = 0;
        cur_entry = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/git_pkg.sv
hdl/git_chan.sv
hdl/git_ctrl.sv
hdl/git_dp.sv
hdl/gradient_interval_table.sv
bench/gradient_interval_table_tb.sv
